@@ rtl/bdhd_pkg.sv @@
// Package with the shared constants of the button debounce and hold detector.
package bdhd_pkg;

    localparam int unsigned      STABLE_MAX_DEF = 255;
    localparam longint unsigned  HOLD_MAX_DEF   = 64'd65535;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 3'd4;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_PRESS = 2'd1;
    localparam logic [1:0] EV_HOLD  = 2'd2;

    localparam logic MODE_DEBOUNCED = 1'b0;
    localparam logic MODE_SIMPLE    = 1'b1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

endpackage

@@ rtl/button_debounce_hold_detector_top.sv @@
// Top level of the button debouncer with press, release and hold detection.
//
//  Channel   Direction  Transfer when             Payload
//  s_axis    in         s_tvalid && s_tready      one pin tick (tdata)
//  m_axis    out        m_tvalid && m_tready      pressed state, flags, event code (tdata)
//  cfg       in         cfg_valid && cfg_ready    register index and write data
//
// A tick is registered at the input, then the result and, while enabled, the state
// registers are updated from it; one tick per cycle is sustained unless the output
// stalls. The state update register is the only stage the counters pass. Reset clears
// valid and detector state and loads the register defaults. A stalled output holds
// its result and the input register; the input stops taking ticks once both are full.
module button_debounce_hold_detector_top #(
    parameter int unsigned     STABLE_MAX = bdhd_pkg::STABLE_MAX_DEF,
    parameter longint unsigned HOLD_MAX   = bdhd_pkg::HOLD_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_level[0], elapsed_ms[16:1], ack_press[17], ack_release[18], ack_hold[19]
    input  logic [bdhd_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // is_pressed[0], press_flag[1], release_flag[2], hold_flag[3], event_code[5:4]
    output logic [bdhd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdhd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bdhd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW   = $clog2(STABLE_MAX + 1);
    localparam int CW   = (SW > 8) ? SW : 8;
    localparam int HW   = $clog2(HOLD_MAX + 64'd1);
    localparam int HCW  = (HW > 16) ? HW : 16;
    localparam int SUMW = HCW + 1;

    localparam logic [SW-1:0]   STABLE_SAT = SW'(STABLE_MAX);
    localparam logic [HW-1:0]   HOLD_SAT   = HW'(HOLD_MAX);
    localparam logic [SUMW-1:0] HOLD_SUM   = SUMW'(HOLD_MAX);

    logic        enable_reg;
    logic        active_low_reg;
    logic [15:0] hold_time_reg;
    logic [7:0]  debounce_time_reg;
    logic        mode_reg;

    logic                           in_valid_reg;
    logic [bdhd_pkg::IN_DATA_W-1:0] in_data_reg;
    logic                           out_valid_reg;
    logic [bdhd_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [bdhd_pkg::OUT_DATA_W-1:0] out_data_next;

    logic          candidate_reg, candidate_next;
    logic [SW-1:0] stable_reg, stable_next;
    logic          pressed_reg, pressed_next;
    logic [HW-1:0] hold_reg, hold_next;
    logic          press_ev_reg, press_ev_next;
    logic          release_ev_reg, release_ev_next;
    logic          hold_ev_reg, hold_ev_next;

    logic            advance;
    logic            fire;
    logic            down;
    logic [15:0]     elapsed;
    logic [CW-1:0]   need;
    logic [HW-1:0]   hold_mid;
    logic [SUMW-1:0] hold_sum;
    logic [1:0]      event_code;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            active_low_reg    <= 1'b1;
            hold_time_reg     <= 16'd1000;
            debounce_time_reg <= 8'd20;
            mode_reg          <= bdhd_pkg::MODE_DEBOUNCED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bdhd_pkg::REG_ENABLE:        enable_reg        <= cfg_data[0];
                bdhd_pkg::REG_ACTIVE_LOW:    active_low_reg    <= cfg_data[0];
                bdhd_pkg::REG_HOLD_TIME:     hold_time_reg     <= cfg_data;
                bdhd_pkg::REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data[7:0];
                bdhd_pkg::REG_MODE:          mode_reg          <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        candidate_next  = candidate_reg;
        stable_next     = stable_reg;
        pressed_next    = pressed_reg;
        hold_next       = hold_reg;
        press_ev_next   = press_ev_reg;
        release_ev_next = release_ev_reg;
        hold_ev_next    = hold_ev_reg;
        event_code      = bdhd_pkg::EV_NONE;
        down            = in_data_reg[0] ^ active_low_reg;
        elapsed         = in_data_reg[16:1];
        need            = (debounce_time_reg == 8'd0) ? CW'(1) : CW'(debounce_time_reg);
        hold_mid        = hold_reg;
        hold_sum        = SUMW'(hold_reg) + SUMW'(elapsed);

        if (mode_reg == bdhd_pkg::MODE_DEBOUNCED)
        begin
            if (in_data_reg[17])
            begin
                press_ev_next = 1'b0;
            end
            if (in_data_reg[18])
            begin
                release_ev_next = 1'b0;
            end
            if (in_data_reg[19])
            begin
                hold_ev_next = 1'b0;
            end

            if (down == candidate_reg)
            begin
                if (stable_reg < STABLE_SAT)
                begin
                    stable_next = stable_reg + SW'(1);
                end
            end
            else
            begin
                stable_next    = '0;
                candidate_next = down;
            end

            if ((CW'(stable_next) >= need) && (pressed_reg != down))
            begin
                pressed_next = down;
                if (down)
                begin
                    press_ev_next = 1'b1;
                end
                else
                begin
                    release_ev_next = 1'b1;
                end
                hold_mid = '0;
            end

            hold_next = hold_mid;
            if (pressed_next)
            begin
                if (hold_mid < HOLD_SAT)
                begin
                    hold_next = hold_mid + HW'(1);
                end
                if (!hold_ev_next && (HCW'(hold_next) >= HCW'(hold_time_reg)))
                begin
                    hold_ev_next = 1'b1;
                end
            end
        end
        else
        begin
            if (down)
            begin
                if (!pressed_reg)
                begin
                    event_code   = bdhd_pkg::EV_PRESS;
                    hold_next    = '0;
                    hold_ev_next = 1'b0;
                    pressed_next = 1'b1;
                end
                else
                begin
                    hold_next = (hold_sum > HOLD_SUM) ? HOLD_SAT : HW'(hold_sum);
                    if (!hold_ev_reg && (HCW'(hold_next) >= HCW'(hold_time_reg)))
                    begin
                        event_code   = bdhd_pkg::EV_HOLD;
                        hold_ev_next = 1'b1;
                    end
                end
            end
            else
            begin
                pressed_next = 1'b0;
                hold_next    = '0;
                hold_ev_next = 1'b0;
            end
        end

        out_data_next = {2'b00, event_code, hold_ev_next, release_ev_next,
                         press_ev_next, pressed_next};
        if (!enable_reg)
        begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            candidate_reg  <= 1'b0;
            stable_reg     <= '0;
            pressed_reg    <= 1'b0;
            hold_reg       <= '0;
            press_ev_reg   <= 1'b0;
            release_ev_reg <= 1'b0;
            hold_ev_reg    <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end

            if (fire && enable_reg)
            begin
                candidate_reg  <= candidate_next;
                stable_reg     <= stable_next;
                pressed_reg    <= pressed_next;
                hold_reg       <= hold_next;
                press_ev_reg   <= press_ev_next;
                release_ev_reg <= release_ev_next;
                hold_ev_reg    <= hold_ev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
